@@ rtl/srs_pkg.sv @@
// Shared types and constants for the stable record insertion sorter.
// No dependencies.

package srs_pkg;

    localparam int SRS_CAPACITY = 8;

    typedef struct packed {
        logic [15:0] card_id;
        logic [7:0]  attack;
        logic [7:0]  defense;
        logic [7:0]  key;
        logic [7:0]  rarity;
    } rec_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;     // place the incoming record, shift larger keys right
        logic shift_out;  // drain: every cell takes its right neighbor
    } cell_ctrl_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

endpackage

@@ rtl/srs_if.sv @@
// Valid/ready channel interfaces for the sorter: record input and sorted result output.
// No dependencies.

interface srs_in_if ();
    logic        valid;
    logic        ready;
    logic [15:0] card_id;
    logic [7:0]  attack_value;
    logic [7:0]  defense_value;
    logic [7:0]  sort_key;
    logic [7:0]  rarity_value;
    logic        last_record;

    modport source (
        output valid, card_id, attack_value, defense_value, sort_key, rarity_value,
               last_record,
        input  ready
    );
    modport sink (
        input  valid, card_id, attack_value, defense_value, sort_key, rarity_value,
               last_record,
        output ready
    );
endinterface

interface srs_out_if ();
    logic        valid;
    logic        ready;
    logic [15:0] out_card_id;
    logic [7:0]  out_attack;
    logic [7:0]  out_defense;
    logic [7:0]  out_key;
    logic [7:0]  out_rarity;
    logic        last_result;
    logic        overflow;

    modport source (
        output valid, out_card_id, out_attack, out_defense, out_key, out_rarity,
               last_result, overflow,
        input  ready
    );
    modport sink (
        input  valid, out_card_id, out_attack, out_defense, out_key, out_rarity,
               last_result, overflow,
        output ready
    );
endinterface

@@ rtl/stable_record_insertion_sorter.sv @@
// Top level of the stable record insertion sorter: count, drain control and the cell chain.
// Depends on srs_pkg, srs_if (srs_in_if, srs_out_if) and srs_cell.
//
//  channel   | dir | payload                                          | transfer
//  ----------+-----+--------------------------------------------------+-------------------
//  records   | in  | card_id, attack/defense/sort_key/rarity, last    | valid && ready
//  results   | out | out_card_id .. out_rarity, last_result, overflow | valid && ready
//
// Filling: one record per cycle; all cells compare against it in parallel.
// After the last record of a set, the N held records (N <= CAPACITY) leave one per
// cycle from cell 0 while results is ready, as the chain shifts left; records stays
// not-ready until the final result transfer.
// Reset clears the count, overflow flag and state; cell contents are don't-care.
// Results back-pressure simply holds the chain.

module stable_record_insertion_sorter
    import srs_pkg::*;
#(
    parameter int CAPACITY = SRS_CAPACITY
)
(
    input logic      clk,
    input logic      rst_n,
    srs_in_if.sink   records,
    srs_out_if.source results
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          dropped_reg;
    logic          dropped_next;

    logic       in_xfer;
    logic       out_xfer;
    logic       full;
    cell_ctrl_t ctrl;
    rec_t       new_rec;

    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] move;
    rec_t                cell_rec [CAPACITY];

    assign in_xfer  = records.valid && records.ready;
    assign out_xfer = results.valid && results.ready;
    assign full     = (count_reg == CW'(CAPACITY));

    assign ctrl.insert    = in_xfer && !full;
    assign ctrl.shift_out = out_xfer;

    assign new_rec.card_id = records.card_id;
    assign new_rec.attack  = records.attack_value;
    assign new_rec.defense = records.defense_value;
    assign new_rec.key     = records.sort_key;
    assign new_rec.rarity  = records.rarity_value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign occ[gi] = (CW'(gi) < count_reg);

            srs_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .new_rec   (new_rec),
                .occ       (occ[gi]),
                .prev_move ((gi == 0) ? 1'b0 : move[(gi == 0) ? 0 : gi - 1]),
                .prev_rec  (cell_rec[(gi == 0) ? 0 : gi - 1]),
                .next_rec  (cell_rec[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .move      (move[gi]),
                .rec       (cell_rec[gi])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_xfer && records.last_record)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_xfer && results.last_result)
                    state_next = ST_FILL;
            end
            default:
                state_next = ST_FILL;
        endcase
    end

    // Outputs
    always_comb
    begin
        records.ready = 1'b0;
        results.valid = 1'b0;
        case (state_reg)
            ST_FILL:  records.ready = 1'b1;
            ST_DRAIN: results.valid = 1'b1;
            default:
            begin
                records.ready = 1'b0;
                results.valid = 1'b0;
            end
        endcase
    end

    assign results.out_card_id = cell_rec[0].card_id;
    assign results.out_attack  = cell_rec[0].attack;
    assign results.out_defense = cell_rec[0].defense;
    assign results.out_key     = cell_rec[0].key;
    assign results.out_rarity  = cell_rec[0].rarity;
    assign results.last_result = (count_reg == CW'(1));
    assign results.overflow    = dropped_reg;

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (ctrl.insert)
            count_next = count_reg + CW'(1);
        else if (out_xfer)
            count_next = count_reg - CW'(1);
        if (in_xfer && full)
            dropped_next = 1'b1;
        else if (out_xfer && results.last_result)
            dropped_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    a_valid_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (count_reg != '0))
        else $error("result offered from an empty chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("record count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.insert && !records.last_record) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance the count");

    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && results.last_result) |=> (records.ready && !dropped_reg
                                               && count_reg == '0))
        else $error("chain not cleared after final result");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && count_reg > CW'(1)) |-> (cell_rec[0].key <= cell_rec[1].key))
        else $error("chain head out of order");

endmodule

@@ rtl/srs_cell.sv @@
// One cell of the insertion chain: holds a single record, compares it with the
// incoming one and trades data with its neighbors. Depends on srs_pkg.

module srs_cell
    import srs_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  rec_t       new_rec,
    input  logic       occ,        // this cell holds a record of the current set
    input  logic       prev_move,  // left neighbor moves right on insert
    input  rec_t       prev_rec,
    input  rec_t       next_rec,
    output logic       move,
    output rec_t       rec
);

    rec_t rec_reg;
    rec_t rec_next;

    // Strict greater-than keeps equal keys in arrival order
    assign move = !occ || (rec_reg.key > new_rec.key);
    assign rec  = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.insert)
        begin
            if (prev_move)
                rec_next = prev_rec;
            else if (move)
                rec_next = new_rec;
        end
        else if (ctrl.shift_out)
        begin
            rec_next = next_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule
